// ===== hw/rtl/ilom_pkg.sv =====
// shared types and codes for the interval list outline merge block
// no dependencies; imported by ilom_ctrl, ilom_dpath and the top level
`default_nettype none

package ilom_pkg;

    localparam int FIELD_BITS = 16;

    typedef enum logic [1:0] {
        OP_LOAD_PREV = 2'd0,
        OP_LOAD_CUR  = 2'd1,
        OP_RUN       = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_STEP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic wr_span;   // store a loaded span
        logic emit_err;  // reject a load
        logic start;     // latch run context
        logic init;      // take first span of each list
        logic step;      // one merge step, or the empty-run result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_ok;
        logic run_ok;
        logic out_free;
        logic finish;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/ilom_ctrl.sv =====
// controller state machine: input handshake, opcode decode, run sequencing
// depends on ilom_pkg
`default_nettype none

module ilom_ctrl
    import ilom_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic       i_flush_only,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    case (t_opcode'(i_opcode))
                        OP_LOAD_PREV, OP_LOAD_CUR: begin
                            if (i_status.load_ok) begin
                                o_cmd.wr_span = 1'b1;
                            end else begin
                                o_cmd.emit_err = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            if (!i_flush_only && i_status.run_ok) begin
                                o_cmd.start = 1'b1;
                                n_state     = ST_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.finish) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ilom_dpath.sv =====
// datapath: span memory with two read ports, per-line counts and bank select,
// merge registers and the result register; depends on ilom_pkg
`default_nettype none

module ilom_dpath
    import ilom_pkg::*;
#(
    parameter int LINES          = 8,
    parameter int SPANS_PER_LIST = 16,
    parameter int COORD_BITS     = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_data,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [2:0]            i_line_index,
    input  wire logic [FIELD_BITS-1:0] i_span_start,
    input  wire logic [FIELD_BITS-1:0] i_span_end,
    input  wire logic [FIELD_BITS-1:0] i_row,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [FIELD_BITS-1:0]      o_span_start_res,
    output logic [FIELD_BITS-1:0]      o_span_end_res,
    output logic [FIELD_BITS-1:0]      o_row_res,
    output logic                       o_last,
    output logic                       o_no_span,
    output logic                       o_error
);

    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SW    = (SPANS_PER_LIST > 1) ? $clog2(SPANS_PER_LIST) : 1;
    localparam int CNW   = $clog2(SPANS_PER_LIST + 1);
    localparam int CB    = COORD_BITS;
    localparam int CW    = COORD_BITS + 1;
    localparam int AW    = LW + 1 + SW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] BEYOND = {1'b1, {CB{1'b0}}};

    // span memory, entry = {start, end}, address = {line, bank, index}
    logic [2*CB-1:0] mem [DEPTH];
    logic [2*CB-1:0] r_rd_a;
    logic [2*CB-1:0] r_rd_b;

    logic            r_sel      [LINES];
    logic [CNW-1:0]  r_cnt_prev [LINES];
    logic [CNW-1:0]  r_cnt_cur  [LINES];
    logic            r_outline_en;

    // run context
    logic [LW-1:0]   r_line;
    logic            r_bank_a;
    logic [FIELD_BITS-1:0] r_row;
    logic [CNW-1:0]  r_na, r_nb, r_ia, r_ib;
    logic [CNW-1:0]  n_ia, n_ib;
    logic [CW-1:0]   r_as, r_ae, r_bs, r_be;
    logic [CW-1:0]   n_as, n_ae, n_bs, n_be;

    // result register
    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_out_s, r_out_e, r_out_row;
    logic                  r_out_last, r_out_none, r_out_err;

    // load side
    logic [LW-1:0]   w_in_line;
    logic            w_line_ok;
    logic [CB-1:0]   w_s, w_e;
    logic            w_to_prev;
    logic            w_bank;
    logic [CNW-1:0]  w_cnt;
    logic            w_full;

    assign w_in_line = LW'(i_line_index);
    assign w_line_ok = 32'(i_line_index) < LINES;
    assign w_s       = CB'(i_span_start);
    assign w_e       = CB'(i_span_end);
    assign w_to_prev = (t_opcode'(i_opcode) == OP_LOAD_PREV);
    assign w_bank    = w_to_prev ? r_sel[w_in_line] : !r_sel[w_in_line];
    assign w_cnt     = w_to_prev ? r_cnt_prev[w_in_line] : r_cnt_cur[w_in_line];
    assign w_full    = 32'(w_cnt) >= SPANS_PER_LIST;

    // merge step
    logic            w_both_done;
    logic            w_fa_v, w_fb_v;
    logic [CW-1:0]   w_fetch_as, w_fetch_ae, w_fetch_bs, w_fetch_be;
    logic [CW-1:0]   t_as, t_ae, t_bs, t_be, w_fill_s, w_fill_e;
    logic [CW-1:0]   w_nx_as, w_nx_ae, w_nx_bs, w_nx_be;
    logic            w_take_a;
    logic            w_fill_last;
    logic            w_adv;

    assign w_both_done = r_as[CB] && r_bs[CB];
    assign w_fa_v      = r_ia < r_na;
    assign w_fb_v      = r_ib < r_nb;
    assign w_fetch_as  = w_fa_v ? {1'b0, r_rd_a[2*CB-1:CB]} : BEYOND;
    assign w_fetch_ae  = w_fa_v ? {1'b0, r_rd_a[CB-1:0]}    : BEYOND;
    assign w_fetch_bs  = w_fb_v ? {1'b0, r_rd_b[2*CB-1:CB]} : BEYOND;
    assign w_fetch_be  = w_fb_v ? {1'b0, r_rd_b[CB-1:0]}    : BEYOND;

    always_comb begin
        t_as     = r_as;
        t_ae     = r_ae;
        t_bs     = r_bs;
        t_be     = r_be;
        w_take_a = 1'b0;
        if (r_as <= r_bs) begin
            w_fill_s = r_as;
            if (r_ae < r_bs) begin
                w_fill_e = r_ae;
                w_take_a = 1'b1;
            end else begin
                w_fill_e = r_bs;
                t_as     = r_bs;
                if (r_ae < r_be) begin
                    t_bs     = r_ae;
                    w_take_a = 1'b1;
                end else begin
                    t_as = r_be;
                end
            end
        end else begin
            w_fill_s = r_bs;
            if (r_be < r_as) begin
                w_fill_e = r_be;
            end else begin
                w_fill_e = r_as;
                t_bs     = r_as;
                if (r_ae < r_be) begin
                    t_bs     = r_ae;
                    w_take_a = 1'b1;
                end else begin
                    t_as = r_be;
                end
            end
        end
        w_nx_as = w_take_a ? w_fetch_as : t_as;
        w_nx_ae = w_take_a ? w_fetch_ae : t_ae;
        w_nx_bs = w_take_a ? t_bs : w_fetch_bs;
        w_nx_be = w_take_a ? t_be : w_fetch_be;
    end

    assign w_fill_last = w_nx_as[CB] && w_nx_bs[CB];
    assign w_adv       = i_cmd.step && !w_both_done;

    always_comb begin
        n_ia = r_ia;
        n_ib = r_ib;
        n_as = r_as;
        n_ae = r_ae;
        n_bs = r_bs;
        n_be = r_be;
        if (i_cmd.start) begin
            n_ia = '0;
            n_ib = '0;
        end else if (i_cmd.init) begin
            n_ia = r_ia + CNW'(w_fa_v);
            n_ib = r_ib + CNW'(w_fb_v);
            n_as = w_fetch_as;
            n_ae = w_fetch_ae;
            n_bs = w_fetch_bs;
            n_be = w_fetch_be;
        end else if (w_adv) begin
            if (w_take_a) begin
                n_ia = r_ia + CNW'(w_fa_v);
            end else begin
                n_ib = r_ib + CNW'(w_fb_v);
            end
            n_as = w_nx_as;
            n_ae = w_nx_ae;
            n_bs = w_nx_bs;
            n_be = w_nx_be;
        end
    end

    // read addresses follow the next pointers so data is ready the next cycle
    logic [LW-1:0] w_rd_line;
    logic          w_rd_bank_a;
    logic [AW-1:0] w_raddr_a, w_raddr_b, w_waddr;

    assign w_rd_line   = i_cmd.start ? w_in_line : r_line;
    assign w_rd_bank_a = i_cmd.start ? r_sel[w_in_line] : r_bank_a;
    assign w_raddr_a   = {w_rd_line, w_rd_bank_a, SW'(n_ia)};
    assign w_raddr_b   = {w_rd_line, !w_rd_bank_a, SW'(n_ib)};
    assign w_waddr     = {w_in_line, w_bank, SW'(w_cnt)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_span) begin
            mem[w_waddr] <= {w_s, w_e};
        end
        r_rd_a <= mem[w_raddr_a];
        r_rd_b <= mem[w_raddr_b];
    end

    logic w_swap;
    assign w_swap = i_cmd.step && (w_both_done || w_fill_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINES; k++) begin
                r_sel[k]      <= 1'b0;
                r_cnt_prev[k] <= '0;
                r_cnt_cur[k]  <= '0;
            end
            r_outline_en <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_outline_en <= i_cfg_data;
            end
            if (i_cmd.wr_span) begin
                if (w_to_prev) begin
                    r_cnt_prev[w_in_line] <= w_cnt + CNW'(1);
                end else begin
                    r_cnt_cur[w_in_line] <= w_cnt + CNW'(1);
                end
            end
            if (w_swap) begin
                r_sel[r_line]      <= !r_sel[r_line];
                r_cnt_prev[r_line] <= r_cnt_cur[r_line];
                r_cnt_cur[r_line]  <= '0;
            end
        end
    end

    // with outlining off both lists read as empty; runs give no_span and swap
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_line   <= w_in_line;
            r_bank_a <= r_sel[w_in_line];
            r_row    <= i_row;
            r_na     <= r_outline_en ? r_cnt_prev[w_in_line] : '0;
            r_nb     <= r_outline_en ? r_cnt_cur[w_in_line] : '0;
        end
        r_ia <= n_ia;
        r_ib <= n_ib;
        r_as <= n_as;
        r_ae <= n_ae;
        r_bs <= n_bs;
        r_be <= n_be;
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_err || i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_s    <= '0;
            r_out_e    <= '0;
            r_out_row  <= '0;
            r_out_last <= 1'b1;
            r_out_none <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (i_cmd.step) begin
            r_out_row <= r_row;
            r_out_err <= 1'b0;
            if (w_both_done) begin
                r_out_s    <= '0;
                r_out_e    <= '0;
                r_out_last <= 1'b1;
                r_out_none <= 1'b1;
            end else begin
                r_out_s    <= FIELD_BITS'(w_fill_s[CB-1:0]);
                r_out_e    <= FIELD_BITS'(w_fill_e[CB-1:0]);
                r_out_last <= w_fill_last;
                r_out_none <= 1'b0;
            end
        end
    end

    assign o_status.load_ok  = w_line_ok && (w_s <= w_e) && !w_full;
    assign o_status.run_ok   = w_line_ok;
    assign o_status.out_free = w_out_free;
    assign o_status.finish   = w_both_done || w_fill_last;

    assign o_out_valid      = r_out_valid;
    assign o_span_start_res = r_out_s;
    assign o_span_end_res   = r_out_e;
    assign o_row_res        = r_out_row;
    assign o_last           = r_out_last;
    assign o_no_span        = r_out_none;
    assign o_error          = r_out_err;

endmodule

`default_nettype wire

// ===== hw/rtl/interval_list_outline_merge_core.sv =====
// top level of the interval list outline merge block
// depends on ilom_pkg, ilom_ctrl and ilom_dpath
//
// Usage: items enter on i_in_valid / o_in_stall, results leave on
// o_out_valid / i_out_stall; a transfer happens when valid is high and stall
// is low. Loads (opcode 0 previous list, 1 current list) give no result,
// unless rejected (start above end, list full, bad line), which gives one
// result with error, no_span and last set. A run (opcode 2) latches its
// context and takes the first span of each list, then gives up to
// 2*SPANS_PER_LIST outline spans, one merge step per cycle while the output
// is not stalled, through the two read ports of the span memory; an empty
// run ends in one no_span result. After the run the lists of the line swap
// and no input is taken meanwhile. Flush-only runs and unknown opcodes give
// nothing. A stall on the output holds the result register and pauses the
// merge; input is stalled while the result register is full and blocked.
// The outline_enable register (reset 1) is written over i_cfg_valid /
// o_cfg_ready, always ready; write it only while idle. Synchronous reset
// empties every list at once, no clearing pass.
`default_nettype none

module interval_list_outline_merge_core
    import ilom_pkg::*;
#(
    parameter int LINES          = 8,
    parameter int SPANS_PER_LIST = 16,
    parameter int COORD_BITS     = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [2:0]            i_line_index,
    input  wire logic [FIELD_BITS-1:0] i_span_start,
    input  wire logic [FIELD_BITS-1:0] i_span_end,
    input  wire logic [FIELD_BITS-1:0] i_row,
    input  wire logic                  i_flush_only,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [FIELD_BITS-1:0]      o_span_start_res,
    output logic [FIELD_BITS-1:0]      o_span_end_res,
    output logic [FIELD_BITS-1:0]      o_row_res,
    output logic                       o_last,
    output logic                       o_no_span,
    output logic                       o_error
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ilom_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_flush_only (i_flush_only),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    ilom_dpath #(
        .LINES          (LINES),
        .SPANS_PER_LIST (SPANS_PER_LIST),
        .COORD_BITS     (COORD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_line_index     (i_line_index),
        .i_span_start     (i_span_start),
        .i_span_end       (i_span_end),
        .i_row            (i_row),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_span_start_res (o_span_start_res),
        .o_span_end_res   (o_span_end_res),
        .o_row_res        (o_row_res),
        .o_last           (o_last),
        .o_no_span        (o_no_span),
        .o_error          (o_error)
    );

endmodule

`default_nettype wire

// ===== bench/interval_list_outline_merge_core_tb.sv =====
// self-checking bench for interval_list_outline_merge_core
// directed table, then random scan bursts; depends on ilom_pkg and the core
`default_nettype none

module interval_list_outline_merge_core_tb
    import ilom_pkg::*;
();

    localparam int NLINES      = 8;
    localparam int NSPANS      = 16;
    localparam int COORD_TOP   = 65534;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 40;
    localparam int PLAN_ROWS   = 22;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // exhausted list presents a start above every coordinate
    localparam logic [FIELD_BITS:0] PAST_END = 17'h1_0000;

    typedef enum {W_MODEL, W_NONE, W_ERROR, W_EMPTY} t_want;

    typedef struct {
        logic [1:0]            op;
        logic [2:0]            line;
        logic [FIELD_BITS-1:0] span_lo;
        logic [FIELD_BITS-1:0] span_hi;
        logic [FIELD_BITS-1:0] row;
        logic                  flush;
    } t_item;

    typedef struct {
        logic [FIELD_BITS-1:0] span_lo;
        logic [FIELD_BITS-1:0] span_hi;
        logic [FIELD_BITS-1:0] row;
        logic                  last;
        logic                  none;
        logic                  err;
    } t_res;

    typedef struct {
        t_item it;
        t_want mode;
    } t_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_data  = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    logic [1:0]            opcode     = '0;
    logic [2:0]            line_index = '0;
    logic [FIELD_BITS-1:0] span_start = '0;
    logic [FIELD_BITS-1:0] span_end   = '0;
    logic [FIELD_BITS-1:0] row_in     = '0;
    logic                  flush_only = 1'b0;

    wire logic                  cfg_ready;
    wire logic                  in_stall;
    wire logic                  out_valid;
    wire logic [FIELD_BITS-1:0] res_lo;
    wire logic [FIELD_BITS-1:0] res_hi;
    wire logic [FIELD_BITS-1:0] res_row;
    wire logic                  res_last;
    wire logic                  res_none;
    wire logic                  res_err;

    // predictor state: span lists per line, counts and the outline switch
    logic [FIELD_BITS-1:0] prev_lo [NLINES][NSPANS];
    logic [FIELD_BITS-1:0] prev_hi [NLINES][NSPANS];
    logic [FIELD_BITS-1:0] cur_lo  [NLINES][NSPANS];
    logic [FIELD_BITS-1:0] cur_hi  [NLINES][NSPANS];
    int prev_n [NLINES];
    int cur_n  [NLINES];
    bit outline_on = 1'b1;

    t_res staged [$];
    t_res fill_q [$];
    t_row plan [PLAN_ROWS];

    bit hold_go  = 1'b0;
    bit hold_off = 1'b0;
    bit calm     = 1'b0;
    int fails    = 0;
    int counted  = 0;
    int runs     = 0;
    int seen     = 0;
    int fills    = 0;
    int rejects  = 0;

    interval_list_outline_merge_core u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_line_index     (line_index),
        .i_span_start     (span_start),
        .i_span_end       (span_end),
        .i_row            (row_in),
        .i_flush_only     (flush_only),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_span_start_res (res_lo),
        .o_span_end_res   (res_hi),
        .o_row_res        (res_row),
        .o_last           (res_last),
        .o_no_span        (res_none),
        .o_error          (res_err)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_res make_res(input logic [FIELD_BITS-1:0] lo,
                                      input logic [FIELD_BITS-1:0] hi,
                                      input logic [FIELD_BITS-1:0] row, input logic last,
                                      input logic none, input logic err);
        t_res r;
        r.span_lo = lo;
        r.span_hi = hi;
        r.row     = row;
        r.last    = last;
        r.none    = none;
        r.err     = err;
        return r;
    endfunction

    function automatic t_item make_item(input logic [1:0] op, input logic [2:0] line,
                                        input logic [FIELD_BITS-1:0] lo,
                                        input logic [FIELD_BITS-1:0] hi,
                                        input logic [FIELD_BITS-1:0] row, input logic flush);
        t_item it;
        it.op      = op;
        it.line    = line;
        it.span_lo = lo;
        it.span_hi = hi;
        it.row     = row;
        it.flush   = flush;
        return it;
    endfunction

    function automatic t_row step_row(input logic [1:0] op, input logic [2:0] line,
                                      input logic [FIELD_BITS-1:0] lo,
                                      input logic [FIELD_BITS-1:0] hi,
                                      input logic [FIELD_BITS-1:0] row, input logic flush,
                                      input t_want mode);
        t_row r;
        r.it   = make_item(op, line, lo, hi, row, flush);
        r.mode = mode;
        return r;
    endfunction

    function automatic void add_fill(input logic [FIELD_BITS:0] lo,
                                     input logic [FIELD_BITS:0] hi,
                                     input logic [FIELD_BITS-1:0] row);
        staged.push_back(make_res(lo[FIELD_BITS-1:0], hi[FIELD_BITS-1:0], row,
                                  1'b0, 1'b0, 1'b0));
    endfunction

    // outline merge predictor: leaves the transfers one item causes in staged
    function automatic void outline_step(input t_item it);
        int ln;
        int pi;
        int ci;
        logic [FIELD_BITS:0] p_lo, p_hi, c_lo, c_hi;
        bit take_prev;
        staged.delete();
        ln = int'(it.line);
        case (it.op)
            OP_LOAD_PREV: begin
                if (it.span_lo > it.span_hi || prev_n[ln] >= NSPANS) begin
                    staged.push_back(make_res('0, '0, '0, 1'b1, 1'b1, 1'b1));
                end else begin
                    prev_lo[ln][prev_n[ln]] = it.span_lo;
                    prev_hi[ln][prev_n[ln]] = it.span_hi;
                    prev_n[ln]++;
                end
            end
            OP_LOAD_CUR: begin
                if (it.span_lo > it.span_hi || cur_n[ln] >= NSPANS) begin
                    staged.push_back(make_res('0, '0, '0, 1'b1, 1'b1, 1'b1));
                end else begin
                    cur_lo[ln][cur_n[ln]] = it.span_lo;
                    cur_hi[ln][cur_n[ln]] = it.span_hi;
                    cur_n[ln]++;
                end
            end
            OP_RUN: begin
                if (!it.flush) begin
                    if (outline_on) begin
                        pi = 0;
                        ci = 0;
                        p_lo = PAST_END;
                        p_hi = PAST_END;
                        c_lo = PAST_END;
                        c_hi = PAST_END;
                        if (pi < prev_n[ln]) begin
                            p_lo = {1'b0, prev_lo[ln][pi]};
                            p_hi = {1'b0, prev_hi[ln][pi]};
                            pi++;
                        end
                        if (ci < cur_n[ln]) begin
                            c_lo = {1'b0, cur_lo[ln][ci]};
                            c_hi = {1'b0, cur_hi[ln][ci]};
                            ci++;
                        end
                        while (p_lo != PAST_END || c_lo != PAST_END) begin
                            if (p_lo <= c_lo) begin
                                if (p_hi < c_lo) begin
                                    add_fill(p_lo, p_hi, it.row);
                                    take_prev = 1'b1;
                                end else begin
                                    add_fill(p_lo, c_lo, it.row);
                                    p_lo = c_lo;
                                    if (p_hi < c_hi) begin
                                        c_lo = p_hi;
                                        take_prev = 1'b1;
                                    end else begin
                                        p_lo = c_hi;
                                        take_prev = 1'b0;
                                    end
                                end
                            end else begin
                                if (c_hi < p_lo) begin
                                    add_fill(c_lo, c_hi, it.row);
                                    take_prev = 1'b0;
                                end else begin
                                    add_fill(c_lo, p_lo, it.row);
                                    c_lo = p_lo;
                                    if (p_hi < c_hi) begin
                                        c_lo = p_hi;
                                        take_prev = 1'b1;
                                    end else begin
                                        p_lo = c_hi;
                                        take_prev = 1'b0;
                                    end
                                end
                            end
                            if (take_prev) begin
                                if (pi < prev_n[ln]) begin
                                    p_lo = {1'b0, prev_lo[ln][pi]};
                                    p_hi = {1'b0, prev_hi[ln][pi]};
                                    pi++;
                                end else begin
                                    p_lo = PAST_END;
                                    p_hi = PAST_END;
                                end
                            end else begin
                                if (ci < cur_n[ln]) begin
                                    c_lo = {1'b0, cur_lo[ln][ci]};
                                    c_hi = {1'b0, cur_hi[ln][ci]};
                                    ci++;
                                end else begin
                                    c_lo = PAST_END;
                                    c_hi = PAST_END;
                                end
                            end
                        end
                    end
                    // current list becomes the previous one
                    for (int k = 0; k < NSPANS; k++) begin
                        prev_lo[ln][k] = cur_lo[ln][k];
                        prev_hi[ln][k] = cur_hi[ln][k];
                    end
                    prev_n[ln] = cur_n[ln];
                    cur_n[ln]  = 0;
                    if (staged.size() == 0)
                        staged.push_back(make_res('0, '0, it.row, 1'b1, 1'b1, 1'b0));
                    else
                        staged[staged.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void match_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endfunction

    task automatic take_result();
        t_res got;
        t_res want;
        got = make_res(res_lo, res_hi, res_row, res_last, res_none, res_err);
        seen++;
        if (got.err)
            rejects++;
        else if (!got.none)
            fills++;
        if (fill_q.size() == 0) begin
            $display("%0t: unexpected transfer, start %0d end %0d row %0d", $time,
                     got.span_lo, got.span_hi, got.row);
            $display("%0t: unexpected transfer, last %0b none %0b err %0b", $time,
                     got.last, got.none, got.err);
            fails++;
        end else begin
            want = fill_q.pop_front();
            match_field("span_start", int'(want.span_lo), int'(got.span_lo));
            match_field("span_end", int'(want.span_hi), int'(got.span_hi));
            match_field("row", int'(want.row), int'(got.row));
            match_field("last", int'(want.last), int'(got.last));
            match_field("no_span", int'(want.none), int'(got.none));
            match_field("error", int'(want.err), int'(got.err));
        end
    endtask

    // output side: check every transfer, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            take_result();
        if (hold_off)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 28);
    end

    // long output hold-off so the core backs up into its input
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic drive_item(input t_item it, input t_want mode);
        while (!calm && $urandom_range(0, 99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= it.op;
        line_index <= it.line;
        span_start <= it.span_lo;
        span_end   <= it.span_hi;
        row_in     <= it.row;
        flush_only <= it.flush;
        do @(posedge clk); while (in_stall);
        outline_step(it);
        case (mode)
            W_MODEL: foreach (staged[k]) fill_q.push_back(staged[k]);
            W_ERROR: fill_q.push_back(make_res('0, '0, '0, 1'b1, 1'b1, 1'b1));
            W_EMPTY: fill_q.push_back(make_res('0, '0, it.row, 1'b1, 1'b1, 1'b0));
            default: ;
        endcase
        if (it.op != OP_UNUSED && !(it.op == OP_RUN && it.flush))
            counted++;
        if (it.op == OP_RUN && !it.flush)
            runs++;
    endtask

    task automatic write_outline(input bit value);
        in_valid <= 1'b0;
        while (fill_q.size() != 0) @(posedge clk);
        // a load or flush may still be in flight with no transfer to show for it
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        outline_on = value;
    endtask

    // ascending spans from base; stops early at the top of the coordinate range
    task automatic load_list(input logic [1:0] op, input logic [2:0] ln, input int cnt,
                             input int base, input int stride);
        int lo;
        int hi;
        lo = base + int'($urandom_range(0, stride));
        for (int k = 0; k < cnt; k++) begin
            hi = lo + int'($urandom_range(0, stride));
            if (hi > COORD_TOP)
                break;
            drive_item(make_item(op, ln, FIELD_BITS'(lo), FIELD_BITS'(hi),
                                 FIELD_BITS'($urandom), 1'b0), W_MODEL);
            lo = hi + 1 + int'($urandom_range(0, stride));
        end
    endtask

    // one scan line: fresh current spans, maybe extra previous spans, then the merge
    task automatic scan_burst();
        logic [2:0] ln;
        int stride;
        int base;
        int np;
        int nc;
        ln     = 3'($urandom_range(0, NLINES - 1));
        stride = ($urandom_range(0, 3) == 0) ? 5000 : 6;
        base   = (stride > 6) ? 0 : int'($urandom_range(0, 65000));
        np     = $urandom_range(0, 1) ? int'($urandom_range(1, 4)) : 0;
        nc     = int'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) begin
            load_list(OP_LOAD_PREV, ln, np, base, stride);
            load_list(OP_LOAD_CUR, ln, nc, base, stride);
        end else begin
            load_list(OP_LOAD_CUR, ln, nc, base, stride);
            load_list(OP_LOAD_PREV, ln, np, base, stride);
        end
        if ($urandom_range(0, 9) == 0)
            drive_item(make_item(OP_RUN, ln, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                                 FIELD_BITS'($urandom), 1'b1), W_MODEL);
        drive_item(make_item(OP_RUN, ln, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                             FIELD_BITS'($urandom), 1'b0), W_MODEL);
    endtask

    // both lists full of interleaved spans, overflow on each, then the widest merge
    task automatic full_burst();
        logic [2:0] ln;
        int base;
        ln   = 3'($urandom_range(0, NLINES - 1));
        base = int'($urandom_range(0, COORD_TOP - 4 * NSPANS));
        repeat (2) drive_item(make_item(OP_RUN, ln, '0, '0, FIELD_BITS'($urandom), 1'b0),
                              W_MODEL);
        for (int k = 0; k < NSPANS; k++) begin
            drive_item(make_item(OP_LOAD_PREV, ln, FIELD_BITS'(base + 4*k),
                                 FIELD_BITS'(base + 4*k + 1), '0, 1'b0), W_MODEL);
            drive_item(make_item(OP_LOAD_CUR, ln, FIELD_BITS'(base + 4*k + 2),
                                 FIELD_BITS'(base + 4*k + 3), '0, 1'b0), W_MODEL);
        end
        drive_item(make_item(OP_LOAD_PREV, ln, FIELD_BITS'(base), FIELD_BITS'(base), '0, 1'b0),
                   W_MODEL);
        drive_item(make_item(OP_LOAD_CUR, ln, FIELD_BITS'(base), FIELD_BITS'(base), '0, 1'b0),
                   W_MODEL);
        drive_item(make_item(OP_RUN, ln, '0, '0, FIELD_BITS'($urandom), 1'b0), W_MODEL);
        drive_item(make_item(OP_RUN, ln, '0, '0, FIELD_BITS'($urandom), 1'b0), W_MODEL);
    endtask

    task automatic noise_item();
        drive_item(make_item(2'($urandom_range(OP_LOAD_PREV, OP_UNUSED)),
                             3'($urandom_range(0, NLINES - 1)),
                             FIELD_BITS'($urandom_range(0, COORD_TOP)),
                             FIELD_BITS'($urandom_range(0, COORD_TOP)),
                             FIELD_BITS'($urandom), 1'($urandom_range(0, 1))), W_MODEL);
    endtask

    task automatic random_phase(input int quota);
        int target;
        target = counted + quota;
        while (counted < target) begin
            if ($urandom_range(0, 99) < 70)
                scan_burst();
            else
                repeat ($urandom_range(1, 3)) noise_item();
        end
    endtask

    initial begin
        foreach (prev_n[k]) begin
            prev_n[k] = 0;
            cur_n[k]  = 0;
        end
        plan = '{
            step_row(OP_RUN,       3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, W_EMPTY),
            step_row(OP_RUN,       3'd7, 16'hffff, 16'hffff, 16'hffff, 1'b1, W_NONE),
            step_row(OP_UNUSED,    3'd3, 16'hfffe, 16'h0000, 16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_PREV, 3'd1, 16'd5,    16'd4,    16'h0000, 1'b0, W_ERROR),
            step_row(OP_LOAD_PREV, 3'd1, 16'd0,    16'd0,    16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_CUR,  3'd1, 16'd0,    16'd0,    16'h0000, 1'b0, W_NONE),
            step_row(OP_RUN,       3'd1, 16'h0000, 16'h0000, 16'h1234, 1'b0, W_MODEL),
            step_row(OP_LOAD_PREV, 3'd2, 16'd0,    16'hfffe, 16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_CUR,  3'd2, 16'd100,  16'd200,  16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_CUR,  3'd2, 16'hfffe, 16'hfffe, 16'h0000, 1'b0, W_NONE),
            step_row(OP_RUN,       3'd2, 16'h0000, 16'h0000, 16'hffff, 1'b0, W_MODEL),
            step_row(OP_RUN,       3'd2, 16'h0000, 16'h0000, 16'h0001, 1'b0, W_MODEL),
            step_row(OP_LOAD_CUR,  3'd3, 16'd10,   16'd20,   16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_PREV, 3'd3, 16'd20,   16'd30,   16'h0000, 1'b0, W_NONE),
            step_row(OP_LOAD_CUR,  3'd3, 16'd40,   16'd50,   16'h0000, 1'b0, W_NONE),
            // out of order in the list, still accepted
            step_row(OP_LOAD_CUR,  3'd3, 16'd30,   16'd35,   16'h0000, 1'b0, W_NONE),
            step_row(OP_RUN,       3'd3, 16'h0000, 16'h0000, 16'haaaa, 1'b0, W_MODEL),
            step_row(OP_LOAD_CUR,  3'd4, 16'hfffe, 16'h0000, 16'hffff, 1'b0, W_ERROR),
            step_row(OP_LOAD_PREV, 3'd5, 16'h5555, 16'haaaa, 16'h0000, 1'b0, W_NONE),
            step_row(OP_RUN,       3'd5, 16'h0000, 16'h0000, 16'h0001, 1'b1, W_NONE),
            step_row(OP_RUN,       3'd5, 16'h0000, 16'h0000, 16'h5555, 1'b0, W_MODEL),
            step_row(OP_RUN,       3'd6, 16'h0000, 16'h0000, 16'h0002, 1'b0, W_EMPTY)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_outline(1'b1);
        foreach (plan[k])
            drive_item(plan[k].it, plan[k].mode);

        hold_go = 1'b1;
        full_burst();
        random_phase(30);
        write_outline(1'b0);
        random_phase(20);
        write_outline(1'b1);
        calm = 1'b1;
        random_phase(20);
        calm = 1'b0;
        random_phase(20);

        in_valid <= 1'b0;
        while (fill_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d items with %0d merges, outline on/off/on, one long hold-off",
                 counted, runs);
        $display("checked %0d transfers: %0d fill spans, %0d rejected loads",
                 seen, fills, rejects);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== interval_list_outline_merge_core.f =====
hw/rtl/ilom_pkg.sv
hw/rtl/ilom_ctrl.sv
hw/rtl/ilom_dpath.sv
hw/rtl/interval_list_outline_merge_core.sv
bench/interval_list_outline_merge_core_tb.sv
